@@ sv/timestamp_ordered_event_queue_defines.svh @@
// Assertion macros for the timestamp-ordered event queue.
`ifndef TIMESTAMP_ORDERED_EVENT_QUEUE_DEFINES_SVH
`define TIMESTAMP_ORDERED_EVENT_QUEUE_DEFINES_SVH
`ifndef ASSERT_OFF
`define TOEQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TOEQ_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TOEQ_ASSERT(label, clk, rst_n, prop, msg)
`define TOEQ_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

@@ sv/toeq_pkg.sv @@
// Package: types and constants of the timestamp-ordered event queue.
`timescale 1ns / 1ps
`default_nettype none
package toeq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] REQ_PUSH  = 2'd0;
	localparam logic [1:0] REQ_POP   = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_NOT_DUE  = 2'd2;

	localparam logic [6:0] CAP_RESET = 7'd64;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [63:0] time_value;
		logic [1:0]  event_kind;
		logic [31:0] event_payload;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        out_valid;
		logic [63:0] out_time;
		logic [1:0]  out_kind;
		logic [31:0] out_payload;
		logic [63:0] head_time;
		logic        queue_empty;
		logic [6:0]  occupancy;
	} rsp_t;

	typedef struct packed {
		logic [63:0] tstamp;
		logic [1:0]  kind;
		logic [31:0] payload;
	} entry_t;

	typedef struct packed {
		logic push_en;
		logic pop_en;
	} cell_ctl_t;

endpackage
`default_nettype wire

@@ sv/timestamp_ordered_event_queue.sv @@
// Top level: timestamp-ordered event queue built as a chain of shift cells.
`timescale 1ns / 1ps
`default_nettype none
`include "timestamp_ordered_event_queue_defines.svh"
// A request is taken in any cycle (busy stays low) and its result strobes on done
// in the cycle after; the receiver cannot stall, so it must take every beat.
// Every cell compares its timestamp with the incoming one in parallel;
// a pop shifts the whole chain one slot toward the head.
// Head time and occupancy in the result show the queue after the request.
module timestamp_ordered_event_queue
	import toeq_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire req_t       req,
	input  wire logic       cfg_we,
	input  wire logic [6:0] cfg_data,
	output logic            done,
	output rsp_t            rsp
);

	logic             accept;
	logic             full;
	logic             due;
	logic [CNT_W-1:0] lim_eff;
	logic [CNT_W-1:0] count_q;
	logic [6:0]       cap_q;
	cell_ctl_t        ctl;
	entry_t           new_entry;
	entry_t           entry_w [QUEUE_DEPTH];
	logic             take_w  [QUEUE_DEPTH];

	logic        done_q;
	logic [1:0]  status_q;
	logic        valid_q;
	logic [63:0] otime_q;
	logic [1:0]  okind_q;
	logic [31:0] opay_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign lim_eff = (cap_q == 7'd0 || 32'(cap_q) > 32'(QUEUE_DEPTH))
		? CNT_W'(QUEUE_DEPTH) : CNT_W'(cap_q);
	assign full = count_q >= lim_eff;
	assign due  = (count_q != '0) && (entry_w[0].tstamp <= req.time_value);

	assign ctl.push_en = accept && (req.req_type == REQ_PUSH) && !full;
	assign ctl.pop_en  = accept && (req.req_type == REQ_POP) && due;

	assign new_entry.tstamp  = req.time_value;
	assign new_entry.kind    = req.event_kind;
	assign new_entry.payload = req.event_payload;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic   occ;
		logic   lt;
		entry_t le;
		entry_t re;

		assign occ = count_q > CNT_W'(i);

		if (i == 0) begin : g_first
			assign lt = 1'b0;
			assign le = '0;
		end else begin : g_mid
			assign lt = take_w[i-1];
			assign le = entry_w[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign re = '0;
		end else begin : g_inner
			assign re = entry_w[i+1];
		end

		toeq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occ         (occ),
			.new_entry   (new_entry),
			.left_take   (lt),
			.left_entry  (le),
			.right_entry (re),
			.take        (take_w[i]),
			.entry_q     (entry_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CAP_RESET;
			done_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			done_q <= accept;
			if (accept && req.req_type == REQ_CLEAR) begin
				count_q <= '0;
			end else if (ctl.push_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.pop_en) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= ST_OK;
			if (req.req_type == REQ_PUSH && full) begin
				status_q <= ST_OVERFLOW;
			end else if (req.req_type == REQ_POP && !due) begin
				status_q <= ST_NOT_DUE;
			end
			valid_q <= ctl.pop_en;
			otime_q <= ctl.pop_en ? entry_w[0].tstamp : 64'd0;
			okind_q <= ctl.pop_en ? entry_w[0].kind : 2'd0;
			opay_q  <= ctl.pop_en ? entry_w[0].payload : 32'd0;
		end
	end

	assign done            = done_q;
	assign rsp.status      = status_q;
	assign rsp.out_valid   = valid_q;
	assign rsp.out_time    = otime_q;
	assign rsp.out_kind    = okind_q;
	assign rsp.out_payload = opay_q;
	assign rsp.head_time   = (count_q != '0) ? entry_w[0].tstamp : 64'd0;
	assign rsp.queue_empty = (count_q == '0);
	assign rsp.occupancy   = 7'(count_q);

	`TOEQ_NEVER(a_count_bound, clk, arst_n, 32'(count_q) > 32'(QUEUE_DEPTH), "occupancy above depth")
	`TOEQ_ASSERT(a_done_follows, clk, arst_n, accept |=> done_q, "result beat missing")
	`TOEQ_ASSERT(a_clear_empties, clk, arst_n, (accept && req.req_type == REQ_CLEAR) |=> (count_q == '0), "clear left events")
	`TOEQ_ASSERT(a_empty_pop, clk, arst_n, (accept && req.req_type == REQ_POP && count_q == '0) |=> (!valid_q && status_q == ST_NOT_DUE), "pop from empty queue delivered")
	`TOEQ_ASSERT(a_push_full, clk, arst_n, (accept && req.req_type == REQ_PUSH && full) |=> $stable(count_q), "push past capacity stored")

endmodule
`default_nettype wire

@@ sv/toeq_cell.sv @@
// One slot of the sorted shift queue: holds an event, shifts right on insert, left on pop.
`timescale 1ns / 1ps
`default_nettype none
module toeq_cell
	import toeq_pkg::*;
(
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire logic      occ,
	input  wire entry_t    new_entry,
	input  wire logic      left_take,
	input  wire entry_t    left_entry,
	input  wire entry_t    right_entry,
	output logic           take,
	output entry_t         entry_q
);

	// slot lies at or beyond the insert point
	assign take = !occ || (entry_q.tstamp > new_entry.tstamp);

	always_ff @(posedge clk) begin
		if (ctl.push_en && take) begin
			entry_q <= left_take ? left_entry : new_entry;
		end else if (ctl.pop_en) begin
			entry_q <= right_entry;
		end
	end

endmodule
`default_nettype wire
